/* sv/egcd_pkg.sv */
// shared types for the extended gcd block: controller states, controller commands and datapath status
package egcd_pkg;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic update;
      logic finish;
   } egcd_cmd_type;

   typedef struct packed {
      logic r1_zero;
      logic step_limit;
      logic ovf_hit;
      logic div_last;
   } egcd_status_type;

endpackage

/* sv/egcd_ctrl.sv */
// controller state machine for the extended gcd block
module egcd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  egcd_pkg::egcd_status_type status_i,
   output egcd_pkg::egcd_cmd_type    cmd_o,
   output logic                     busy,
   output logic                     rsp_strobe
);
   import egcd_pkg::*;

   state_type    state_ff, state_in;
   logic         strobe_ff, strobe_in;
   egcd_cmd_type cmd;

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // loop exit covers zero divisor, step bound and the overflow case
            if (status_i.r1_zero || status_i.step_limit || status_i.ovf_hit) begin
               cmd.finish = 1'b1;
               strobe_in  = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status_i.div_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_CHECK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign cmd_o      = cmd;
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("more than one result strobe for an item");

   a_div_to_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && status_i.div_last) |=> (state_ff == ST_UPDATE))
      else $error("division did not hand over to the coefficient update");

endmodule

/* sv/egcd_datapath.sv */
// datapath for the extended gcd block: remainder chain, bit-serial divider, coefficients
module egcd_datapath #(
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  egcd_pkg::egcd_cmd_type      cmd_i,
   output egcd_pkg::egcd_status_type   status_o,
   input  logic        [WORD_BITS-1:0] a_value,
   input  logic        [WORD_BITS-1:0] b_value,
   output logic        [WORD_BITS-1:0] gcd_value,
   output logic        [WORD_BITS-1:0] coef_a,
   output logic        [WORD_BITS-1:0] coef_b,
   output logic                        overflow
);
   import egcd_pkg::*;

   localparam int CNT_W  = $clog2(WORD_BITS);
   localparam int STEP_W = $clog2(2 * WORD_BITS + 5);
   localparam logic [WORD_BITS-1:0] MIN_VAL = {1'b1, {(WORD_BITS-1){1'b0}}};

   logic [WORD_BITS-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [WORD_BITS-1:0] s0_ff, s0_in, s1_ff, s1_in;
   logic [WORD_BITS-1:0] t0_ff, t0_in, t1_ff, t1_in;
   logic [WORD_BITS-1:0] n_ff, n_in, d_ff, d_in, rem_ff, rem_in;
   logic [WORD_BITS-1:0] acc_s_ff, acc_s_in, acc_t_ff, acc_t_in;
   logic                 neg_r0_ff, neg_r0_in, q_neg_ff, q_neg_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [STEP_W-1:0]    steps_ff, steps_in;
   logic [WORD_BITS-1:0] gcd_ff, gcd_in, coef_a_ff, coef_a_in, coef_b_ff, coef_b_in;
   logic                 ovf_ff, ovf_in;

   logic [WORD_BITS-1:0] r0_mag, r1_mag, r2;
   logic [WORD_BITS:0]   rem_shift, rem_diff;
   logic                 fits, ovf_hit, r1_zero, step_limit;

   assign r0_mag     = r0_ff[WORD_BITS-1] ? (~r0_ff + 1'b1) : r0_ff;
   assign r1_mag     = r1_ff[WORD_BITS-1] ? (~r1_ff + 1'b1) : r1_ff;
   assign r1_zero    = (r1_ff == '0);
   assign step_limit = (steps_ff == STEP_W'(2 * WORD_BITS + 4));
   // most negative value over minus one has no representable quotient
   assign ovf_hit    = (r0_ff == MIN_VAL) && (r1_ff == '1);

   // restoring division, one quotient bit per cycle, msb first
   assign rem_shift = {rem_ff, n_ff[WORD_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, d_ff};
   assign fits      = (rem_shift >= {1'b0, d_ff});

   // truncating remainder takes the sign of the dividend
   assign r2 = neg_r0_ff ? (~rem_ff + 1'b1) : rem_ff;

   always_comb begin
      r0_in     = r0_ff;
      r1_in     = r1_ff;
      s0_in     = s0_ff;
      s1_in     = s1_ff;
      t0_in     = t0_ff;
      t1_in     = t1_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      rem_in    = rem_ff;
      acc_s_in  = acc_s_ff;
      acc_t_in  = acc_t_ff;
      neg_r0_in = neg_r0_ff;
      q_neg_in  = q_neg_ff;
      cnt_in    = cnt_ff;
      steps_in  = steps_ff;
      gcd_in    = gcd_ff;
      coef_a_in = coef_a_ff;
      coef_b_in = coef_b_ff;
      ovf_in    = ovf_ff;

      if (cmd_i.load) begin
         r0_in    = a_value;
         r1_in    = b_value;
         s0_in    = WORD_BITS'(1);
         s1_in    = '0;
         t0_in    = '0;
         t1_in    = WORD_BITS'(1);
         steps_in = '0;
      end
      if (cmd_i.div_init) begin
         n_in      = r0_mag;
         d_in      = r1_mag;
         rem_in    = '0;
         acc_s_in  = '0;
         acc_t_in  = '0;
         cnt_in    = '0;
         neg_r0_in = r0_ff[WORD_BITS-1];
         q_neg_in  = r0_ff[WORD_BITS-1] ^ r1_ff[WORD_BITS-1];
      end
      if (cmd_i.div_step) begin
         n_in     = {n_ff[WORD_BITS-2:0], 1'b0};
         rem_in   = fits ? rem_diff[WORD_BITS-1:0] : rem_shift[WORD_BITS-1:0];
         // accumulate quotient magnitude times s1 and t1 alongside the division
         acc_s_in = {acc_s_ff[WORD_BITS-2:0], 1'b0} + (fits ? s1_ff : '0);
         acc_t_in = {acc_t_ff[WORD_BITS-2:0], 1'b0} + (fits ? t1_ff : '0);
         cnt_in   = cnt_ff + 1'b1;
      end
      if (cmd_i.update) begin
         r0_in    = r1_ff;
         r1_in    = r2;
         s0_in    = s1_ff;
         s1_in    = q_neg_ff ? (s0_ff + acc_s_ff) : (s0_ff - acc_s_ff);
         t0_in    = t1_ff;
         t1_in    = q_neg_ff ? (t0_ff + acc_t_ff) : (t0_ff - acc_t_ff);
         steps_in = steps_ff + 1'b1;
      end
      if (cmd_i.finish) begin
         if (ovf_hit && !r1_zero && !step_limit) begin
            gcd_in    = '0;
            coef_a_in = '0;
            coef_b_in = '0;
            ovf_in    = 1'b1;
         end else begin
            gcd_in    = r0_ff;
            coef_a_in = s0_ff;
            coef_b_in = t0_ff;
            ovf_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         steps_ff <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      s0_ff     <= s0_in;
      s1_ff     <= s1_in;
      t0_ff     <= t0_in;
      t1_ff     <= t1_in;
      n_ff      <= n_in;
      d_ff      <= d_in;
      rem_ff    <= rem_in;
      acc_s_ff  <= acc_s_in;
      acc_t_ff  <= acc_t_in;
      neg_r0_ff <= neg_r0_in;
      q_neg_ff  <= q_neg_in;
      gcd_ff    <= gcd_in;
      coef_a_ff <= coef_a_in;
      coef_b_ff <= coef_b_in;
      ovf_ff    <= ovf_in;
   end

   assign status_o.r1_zero    = r1_zero;
   assign status_o.step_limit = step_limit;
   assign status_o.ovf_hit    = ovf_hit;
   assign status_o.div_last   = (cnt_ff == CNT_W'(WORD_BITS - 1));

   assign gcd_value = gcd_ff;
   assign coef_a    = coef_a_ff;
   assign coef_b    = coef_b_ff;
   assign overflow  = ovf_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd_i.div_step |-> (rem_ff < d_ff))
      else $error("partial remainder not below divisor");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd_i.div_init |=> (d_ff != '0))
      else $error("division started with a zero divisor");

   a_ovf_zero_result: assert property (@(posedge clock) disable iff (reset)
      (cmd_i.finish && ovf_hit && !r1_zero && !step_limit) |=>
         (overflow && gcd_value == '0 && coef_a == '0 && coef_b == '0))
      else $error("overflow result not cleared");

endmodule

/* sv/extended_gcd.sv */
// per Euclid step the controller passes through check, divide and update states;
// a final check registers rsp_strobe; the bit-serial divider runs inside each step
// one item at a time
// start is taken again in the strobe cycle; the receiver cannot stall
// synchronous active-high reset returns the controller to idle with no strobe pending
module extended_gcd #(
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [WORD_BITS-1:0] req_a_value,
   input  logic signed [WORD_BITS-1:0] req_b_value,
   output logic                        rsp_strobe,
   output logic signed [WORD_BITS-1:0] rsp_gcd_value,
   output logic signed [WORD_BITS-1:0] rsp_coef_a,
   output logic signed [WORD_BITS-1:0] rsp_coef_b,
   output logic                        rsp_overflow
);
   import egcd_pkg::*;

   egcd_cmd_type    cmd;
   egcd_status_type status;
   logic [WORD_BITS-1:0] gcd_u, coef_a_u, coef_b_u;

   egcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status_i   (status),
      .cmd_o      (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   egcd_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd_i     (cmd),
      .status_o  (status),
      .a_value   (req_a_value),
      .b_value   (req_b_value),
      .gcd_value (gcd_u),
      .coef_a    (coef_a_u),
      .coef_b    (coef_b_u),
      .overflow  (rsp_overflow)
   );

   assign rsp_gcd_value = gcd_u;
   assign rsp_coef_a    = coef_a_u;
   assign rsp_coef_b    = coef_b_u;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// self-checking testbench for extended_gcd: queued driver, strobe monitor and bezout predictor
module tb_top;

   localparam int WORD_BITS = 32;
   localparam int STEP_CYCLES = WORD_BITS + 2;
   localparam int MAX_CHAIN = 2 * WORD_BITS + 4;
   localparam logic [WORD_BITS-1:0] MOST_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS-1:0] MOST_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] MINUS_ONE = '1;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      word_type gcd_value;
      word_type coef_a;
      word_type coef_b;
      logic     overflow;
   } bezout_type;

   typedef struct packed {
      word_type a_value;
      word_type b_value;
      logic     drain_first;
      logic     steady;
   } operand_pair_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic signed [WORD_BITS-1:0] req_a_value = '0;
   logic signed [WORD_BITS-1:0] req_b_value = '0;
   logic                        rsp_strobe;
   logic signed [WORD_BITS-1:0] rsp_gcd_value;
   logic signed [WORD_BITS-1:0] rsp_coef_a;
   logic signed [WORD_BITS-1:0] rsp_coef_b;
   logic                        rsp_overflow;

   operand_pair_type pending_pairs[$];
   bezout_type       expected_results[$];
   int               accepted_count = 0;
   int               checked_count = 0;
   int               mismatch_count = 0;
   int               overflow_count = 0;
   int               zero_b_count = 0;
   int               deepest_chain = 0;

   extended_gcd #(
      .WORD_BITS(WORD_BITS)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_a_value  (req_a_value),
      .req_b_value  (req_b_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_gcd_value(rsp_gcd_value),
      .rsp_coef_a   (rsp_coef_a),
      .rsp_coef_b   (rsp_coef_b),
      .rsp_overflow (rsp_overflow)
   );

   always #5 clock = ~clock;

   // truncating remainder chain carrying both coefficient pairs, all modulo 2^WORD_BITS
   function automatic bezout_type bezout_predict(input word_type a, input word_type b,
                                                 output int chain_len);
      word_type   r0, r1, r2, s0, s1, s2, t0, t1, t2, mag0, mag1, quot;
      bit         div_ovf;
      bezout_type res;
      r0 = a;
      r1 = b;
      s0 = 1;
      s1 = 0;
      t0 = 0;
      t1 = 1;
      chain_len = 0;
      div_ovf = 1'b0;
      while (r1 != 0 && chain_len < MAX_CHAIN) begin
         if (r0 == MOST_NEG && r1 == MINUS_ONE) begin
            div_ovf = 1'b1;
            break;
         end
         mag0 = r0[WORD_BITS-1] ? word_type'(0) - r0 : r0;
         mag1 = r1[WORD_BITS-1] ? word_type'(0) - r1 : r1;
         quot = mag0 / mag1;
         if (r0[WORD_BITS-1] != r1[WORD_BITS-1])
            quot = word_type'(0) - quot;
         r2 = r0 - quot * r1;
         s2 = s0 - quot * s1;
         t2 = t0 - quot * t1;
         r0 = r1;
         r1 = r2;
         s0 = s1;
         s1 = s2;
         t0 = t1;
         t1 = t2;
         chain_len++;
      end
      if (div_ovf)
         res = '{gcd_value: '0, coef_a: '0, coef_b: '0, overflow: 1'b1};
      else
         res = '{gcd_value: r0, coef_a: s0, coef_b: t0, overflow: 1'b0};
      return res;
   endfunction

   task automatic add_pair(input word_type a, input word_type b, input bit drain,
                           input bit steady);
      operand_pair_type p;
      p = '{a_value: a, b_value: b, drain_first: drain, steady: steady};
      pending_pairs.push_back(p);
   endtask

   // driver: start may drop while busy, the offered item stays at the head until taken
   always @(negedge clock) begin
      if (reset || pending_pairs.size() == 0) begin
         start <= 1'b0;
      end else if (pending_pairs[0].drain_first && expected_results.size() != 0) begin
         start <= 1'b0;
      end else if (!pending_pairs[0].steady && $urandom_range(0, 99) < 26) begin
         start <= 1'b0;
      end else begin
         start       <= 1'b1;
         req_a_value <= pending_pairs[0].a_value;
         req_b_value <= pending_pairs[0].b_value;
      end
   end

   // monitor: check strobed results, then record the item taken at this edge
   always @(posedge clock) begin : monitor
      bezout_type got;
      bezout_type want;
      int         chain_len;
      if (!reset && rsp_strobe) begin
         got = {rsp_gcd_value, rsp_coef_a, rsp_coef_b, rsp_overflow};
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result with no item outstanding: g=%0d x=%0d y=%0d ovf=%0b",
                        $realtime, rsp_gcd_value, rsp_coef_a, rsp_coef_b, rsp_overflow);
         end else begin
            want = expected_results.pop_front();
            checked_count++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"%0t: mismatch exp g=%0d x=%0d y=%0d ovf=%0b",
                            " got g=%0d x=%0d y=%0d ovf=%0b"},
                           $realtime, $signed(want.gcd_value), $signed(want.coef_a),
                           $signed(want.coef_b), want.overflow, $signed(got.gcd_value),
                           $signed(got.coef_a), $signed(got.coef_b), got.overflow);
            end
         end
      end
      if (!reset && start && !busy) begin
         want = bezout_predict(req_a_value, req_b_value, chain_len);
         expected_results.push_back(want);
         void'(pending_pairs.pop_front());
         accepted_count++;
         if (want.overflow)
            overflow_count++;
         if (req_b_value == 0)
            zero_b_count++;
         if (chain_len > deepest_chain)
            deepest_chain = chain_len;
      end
   end

   initial begin
      int       fib[0:46];
      word_type corner_values[6];
      word_type a;
      word_type b;
      word_type g;
      int       k;
      int       pick;
      bit       steady;
      bit       drain;

      fib[0] = 0;
      fib[1] = 1;
      for (k = 2; k <= 46; k++)
         fib[k] = fib[k-1] + fib[k-2];
      corner_values = '{MOST_NEG, MOST_POS, MINUS_ONE, word_type'(0), word_type'(1),
                        MOST_NEG + 1};

      // directed: zeros, extremes, both overflow paths, deepest chain, sign combinations
      add_pair(0, 0, 0, 0);
      add_pair(25, 0, 0, 0);
      add_pair(0, -7, 0, 0);
      add_pair(MOST_NEG, MINUS_ONE, 0, 0);
      add_pair(MINUS_ONE, MOST_NEG, 0, 0);
      add_pair(MOST_NEG, MOST_NEG, 0, 0);
      add_pair(MOST_POS, MOST_POS, 0, 0);
      add_pair(MOST_POS, MOST_NEG, 0, 0);
      add_pair(MOST_NEG, MOST_POS, 0, 0);
      add_pair(MOST_NEG, 1, 0, 0);
      add_pair(MOST_NEG, 0, 0, 0);
      add_pair(MOST_NEG, 2, 0, 0);
      add_pair(MOST_POS, MINUS_ONE, 0, 0);
      add_pair(fib[46], fib[45], 0, 0);
      add_pair(-fib[46], fib[45], 0, 0);
      add_pair(240, 46, 0, 0);
      add_pair(-240, 46, 0, 0);
      add_pair(240, -46, 0, 0);
      add_pair(-240, -46, 0, 0);
      add_pair(1, 1, 0, 0);
      add_pair(MINUS_ONE, MINUS_ONE, 0, 0);
      add_pair(12345678, 0, 0, 0);

      for (int i = 0; i < 400; i++) begin
         steady = (i >= 150 && i < 250);
         drain = (i == 0 || i == 200);
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            a = $urandom;
            b = $urandom;
         end else if (pick < 45) begin
            a = $urandom_range(0, 2000) - 1000;
            b = $urandom_range(0, 2000) - 1000;
         end else if (pick < 60) begin
            // shared factor so the divisor is not trivially one
            g = $urandom_range(1, 5000);
            a = g * $urandom_range(0, 400000);
            b = g * $urandom_range(0, 400000);
            if ($urandom_range(0, 1))
               a = word_type'(0) - a;
            if ($urandom_range(0, 1))
               b = word_type'(0) - b;
         end else if (pick < 70) begin
            // consecutive fibonacci numbers give the longest chains
            k = $urandom_range(2, 45);
            a = fib[k+1];
            b = fib[k];
            if ($urandom_range(0, 1)) begin
               a = fib[k];
               b = fib[k+1];
            end
            if ($urandom_range(0, 1))
               a = word_type'(0) - a;
            if ($urandom_range(0, 1))
               b = word_type'(0) - b;
         end else if (pick < 80) begin
            a = $urandom;
            b = corner_values[$urandom_range(2, 4)];
            if ($urandom_range(0, 1)) begin
               g = a;
               a = b;
               b = g;
            end
         end else if (pick < 90) begin
            a = corner_values[$urandom_range(0, 5)];
            b = corner_values[$urandom_range(0, 5)];
         end else begin
            a = $urandom >> $urandom_range(0, WORD_BITS - 1);
            b = $urandom >> $urandom_range(0, WORD_BITS - 1);
            if ($urandom_range(0, 1))
               a = word_type'(0) - a;
            if ($urandom_range(0, 1))
               b = word_type'(0) - b;
         end
         add_pair(a, b, drain, steady);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_pairs.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (2 * STEP_CYCLES + 2) @(posedge clock);

      $display("tb_top: %0d operand pairs accepted, %0d results checked, %0d with overflow",
               accepted_count, checked_count, overflow_count);
      $display("tb_top: %0d pairs with zero second operand, longest chain %0d steps",
               zero_b_count, deepest_chain);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("tb_top: timeout, %0d items waiting, %0d results outstanding",
               pending_pairs.size(), expected_results.size());
      $display("tb_top: errors");
      $finish;
   end

endmodule
